// ===== sv/svcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcs_pkg
// shared types and constants of the stepper velocity command sequencer
// ----------------------------------------------------------------------------
package svcs_pkg;

  localparam int unsigned NumMotors = 2;
  localparam int unsigned PosBits   = 22;
  localparam int unsigned MotorW    = (NumMotors > 1) ? $clog2(NumMotors) : 1;

  typedef enum logic [1:0] {
    CFG_MIN_SPEED    = 2'd0,
    CFG_KICK_TIMEOUT = 2'd1,
    CFG_KICK_ENABLE  = 2'd2,
    CFG_MICROSTEPS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_STOPPED      = 3'd0,
    MODE_FWD          = 3'd1,
    MODE_REV          = 3'd2,
    MODE_FWD_STOPPING = 3'd3,
    MODE_REV_STOPPING = 3'd4
  } motor_mode_e;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_RUN       = 2'd1,
    CMD_SOFT_STOP = 2'd2
  } command_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_MULT   = 3'd1,
    ST_DIV    = 3'd2,
    ST_UPDATE = 3'd3,
    ST_OUT    = 3'd4
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input word
    logic mult;     // form products
    logic div_step; // one bit of both divisions
    logic update;   // state update and result capture
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

// ===== sv/stepper_velocity_command_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_velocity_command_sequencer
// per-motor run/stop command sequencing from a requested angular rate
// ----------------------------------------------------------------------------
// One word at a time: a word for a valid motor passes capture, the multiply
// state, 52 steps of two bit-serial restoring dividers that step together and
// form speed and moved angle, and update, then waits out any output stall;
// the next word is taken in the cycle after the result leaves. A word for a
// motor index at or above the motor count is taken and gives no result.
module stepper_velocity_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  motor_index_i,
  input  logic [31:0] angle_rate_i,
  input  logic [31:0] period_i,
  input  logic [15:0] speed_limit_i,
  input  logic [19:0] steps_per_degree_i,
  input  logic        driver_busy_i,
  input  logic [21:0] driver_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  command_o,
  output logic        direction_o,
  output logic [23:0] run_speed_o,
  output logic        kick_o,
  output logic [21:0] moved_microsteps_o,
  output logic [31:0] moved_angle_o,
  output logic [2:0]  motor_mode_out_o
);
  import svcs_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  svcs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i,
    .in_motor_index_i (motor_index_i),
    .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o    (dp_cmd),
    .status_i (dp_status)
  );

  svcs_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .motor_index_i, .angle_rate_i, .period_i, .speed_limit_i,
    .steps_per_degree_i, .driver_busy_i, .driver_position_i,
    .cmd_i    (dp_cmd),
    .status_o (dp_status),
    .command_o, .direction_o, .run_speed_o, .kick_o,
    .moved_microsteps_o, .moved_angle_o, .motor_mode_out_o
  );

endmodule

// ===== sv/svcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcs_ctrl
// sequencing state machine and output handshake
// ----------------------------------------------------------------------------
module svcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_motor_index_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output svcs_pkg::dp_cmd_t    cmd_o,
  input  svcs_pkg::dp_status_t status_i
);
  import svcs_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        in_acc;
  logic        in_range;

  assign in_range = ({30'd0, in_motor_index_i} < NumMotors);
  assign in_acc   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc && in_range) state_d = ST_MULT;
      ST_MULT:   state_d = ST_DIV;
      ST_DIV:    if (status_i.div_done) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_MULT:   cmd_o.mult = 1'b1;
      ST_DIV:    cmd_o.div_step = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == ST_OUT)) else $error("valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("input taken while busy");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
`endif

endmodule

// ===== sv/svcs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svcs_dp
// speed and angle arithmetic, per-motor state, mode machine
// ----------------------------------------------------------------------------
module svcs_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [1:0]           motor_index_i,
  input  logic [31:0]          angle_rate_i,
  input  logic [31:0]          period_i,
  input  logic [15:0]          speed_limit_i,
  input  logic [19:0]          steps_per_degree_i,
  input  logic                 driver_busy_i,
  input  logic [21:0]          driver_position_i,
  input  svcs_pkg::dp_cmd_t    cmd_i,
  output svcs_pkg::dp_status_t status_o,
  output logic [1:0]           command_o,
  output logic                 direction_o,
  output logic [23:0]          run_speed_o,
  output logic                 kick_o,
  output logic [21:0]          moved_microsteps_o,
  output logic [31:0]          moved_angle_o,
  output logic [2:0]           motor_mode_out_o
);
  import svcs_pkg::*;

  // configuration
  logic [23:0] min_speed_q;
  logic [31:0] kick_timeout_q;
  logic        kick_enable_q;
  logic [7:0]  usteps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q    <= 24'd2560;
      kick_timeout_q <= 32'd327680;
      kick_enable_q  <= 1'b1;
      usteps_q       <= 8'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_SPEED:    min_speed_q    <= cfg_data_i[23:0];
        CFG_KICK_TIMEOUT: kick_timeout_q <= cfg_data_i;
        CFG_KICK_ENABLE:  kick_enable_q  <= cfg_data_i[0];
        CFG_MICROSTEPS:   usteps_q       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // captured word
  logic [MotorW-1:0]  m_q;
  logic               rneg_q;
  logic [31:0]        rmag_q;
  logic [31:0]        period_q;
  logic [23:0]        cap_q;
  logic [19:0]        spd_q;
  logic               busy_q;
  logic [PosBits-1:0] pos_q;

  // per-motor state
  motor_mode_e        mode_q  [NumMotors];
  logic [PosBits-1:0] lastp_q [NumMotors];
  logic [31:0]        timer_q [NumMotors];

  // division registers
  logic [51:0] prod_q;      // speed dividend, quotient bits shift in
  logic [32:0] srem_q;
  logic [45:0] adiv_num_q;  // |delta| << 24
  logic [27:0] adiv_d_q;
  logic [27:0] arem_q;
  logic [5:0]  cnt_q;
  logic        dneg_q;
  logic [PosBits-1:0] delta_q;

  logic [PosBits-1:0] delta_w, dmag_w;
  logic [51:0] prod_w;
  assign delta_w = pos_q - lastp_q[m_q];
  assign dmag_w  = delta_w[PosBits-1] ? (~delta_w + 1'b1) : delta_w;
  assign prod_w  = {32'd0, spd_q} * {20'd0, rmag_q};

  // restoring division steps
  logic [32:0] s_try;
  logic [28:0] a_try;
  logic        s_ge, a_ge;
  logic [32:0] s_sh;
  assign s_sh  = {srem_q[31:0], prod_q[51]};
  assign s_ge  = (s_sh >= {1'b0, period_q});
  assign s_try = s_sh - {1'b0, period_q};
  logic [28:0] a_sh;
  assign a_sh  = {arem_q, adiv_num_q[45]};
  assign a_ge  = (a_sh >= {1'b0, adiv_d_q});
  assign a_try = a_sh - {1'b0, adiv_d_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      m_q      <= motor_index_i[MotorW-1:0];
      rneg_q   <= angle_rate_i[31];
      rmag_q   <= angle_rate_i[31] ? (~angle_rate_i + 1'b1) : angle_rate_i;
      period_q <= period_i;
      cap_q    <= {speed_limit_i, 8'd0};
      spd_q    <= steps_per_degree_i;
      busy_q   <= driver_busy_i;
      pos_q    <= driver_position_i[PosBits-1:0];
    end
    if (cmd_i.mult) begin
      prod_q     <= prod_w;
      srem_q     <= '0;
      adiv_num_q <= {dmag_w, 24'd0};
      adiv_d_q   <= {20'd0, usteps_q} * {8'd0, spd_q};
      arem_q     <= '0;
      cnt_q      <= '0;
      dneg_q     <= delta_w[PosBits-1];
      delta_q    <= delta_w;
    end
    if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 6'd1;
      srem_q <= s_ge ? s_try : s_sh;
      prod_q <= {prod_q[50:0], s_ge};
      if (cnt_q < 6'd46) begin
        arem_q     <= a_ge ? a_try[27:0] : a_sh[27:0];
        adiv_num_q <= {adiv_num_q[44:0], a_ge};
      end
    end
  end

  assign status_o.div_done = (cnt_q == 6'd51);

  // update-stage logic; quotients are in prod_q and adiv_num_q after 52 steps
  logic        prod_nz_q;
  logic [51:0] pq;
  logic [23:0] speed_w;
  logic        fwd_w;
  always_ff @(posedge clk_i) if (cmd_i.mult) prod_nz_q <= (prod_w != '0);

  always_comb begin
    pq = prod_q;
    if (!prod_nz_q) speed_w = '0;
    else if (period_q == '0 || pq > {28'd0, cap_q}) speed_w = cap_q;
    else speed_w = pq[23:0];
  end
  assign fwd_w = !rneg_q && prod_nz_q;

  logic [31:0] angle_w;
  logic [45:0] aq;
  always_comb begin
    aq = adiv_num_q;
    if (adiv_d_q == '0) angle_w = '0;
    else if (dneg_q) angle_w = (aq > 46'h80000000) ? 32'h80000000 : (~aq[31:0] + 1'b1);
    else angle_w = (aq > 46'h7FFFFFFF) ? 32'h7FFFFFFF : aq[31:0];
  end

  motor_mode_e mode_nx;
  command_e    cmd_nx;
  always_comb begin
    mode_nx = mode_q[m_q];
    cmd_nx  = CMD_NONE;
    case (mode_q[m_q])
      MODE_STOPPED: begin
        cmd_nx = CMD_RUN; mode_nx = fwd_w ? MODE_FWD : MODE_REV;
      end
      MODE_FWD: begin
        if (fwd_w) cmd_nx = CMD_RUN;
        else begin cmd_nx = CMD_SOFT_STOP; mode_nx = MODE_FWD_STOPPING; end
      end
      MODE_REV: begin
        if (!fwd_w) cmd_nx = CMD_RUN;
        else begin cmd_nx = CMD_SOFT_STOP; mode_nx = MODE_REV_STOPPING; end
      end
      MODE_FWD_STOPPING, MODE_REV_STOPPING: if (!busy_q) mode_nx = MODE_STOPPED;
      default: ;
    endcase
  end

  logic        kick_w;
  logic [31:0] timer_nx;
  logic [32:0] tsum;
  assign tsum = {1'b0, timer_q[m_q]} + {1'b0, period_q};
  always_comb begin
    kick_w   = 1'b0;
    timer_nx = timer_q[m_q];
    if (kick_enable_q && speed_w != '0) begin
      if (speed_w < min_speed_q) begin
        if (timer_q[m_q] >= kick_timeout_q) begin
          kick_w = 1'b1; timer_nx = '0;
        end else timer_nx = tsum[32] ? 32'hFFFFFFFF : tsum[31:0];
      end else timer_nx = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMotors; i++) begin
        mode_q[i]  <= MODE_STOPPED;
        lastp_q[i] <= '0;
        timer_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      mode_q[m_q]  <= mode_nx;
      lastp_q[m_q] <= pos_q;
      timer_q[m_q] <= timer_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      command_o          <= cmd_nx;
      direction_o        <= !fwd_w;
      run_speed_o        <= speed_w;
      kick_o             <= kick_w;
      moved_microsteps_o <= 22'(signed'(delta_q));
      moved_angle_o      <= angle_w;
      motor_mode_out_o   <= mode_nx;
    end
  end

`ifndef SYNTHESIS
  a_speed_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> (speed_w <= cap_q)) else $error("speed above cap");
  a_kick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.update && kick_w) |-> (timer_nx == '0)) else $error("kick without clear");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (cnt_q < 6'd52)) else $error("division overrun");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the stepper velocity command sequencer: a directed
// table of words, then random words and register settings, each result
// compared against a behavioral predictor of command, direction, speed, kick,
// moved steps, angle and mode, or against a typed row of the table
module tb;
  import svcs_pkg::*;

  localparam int unsigned DirectedRows = 22;
  localparam int unsigned RandomWords  = 1550;
  localparam longint      CycleLimit   = 400000;

  typedef struct packed {
    logic [1:0]  motor;
    logic [31:0] rate;
    logic [31:0] period;
    logic [15:0] speed_limit;
    logic [19:0] spd;
    logic        busy;
    logic [21:0] pos;
  } move_word_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        dir;
    logic [23:0] speed;
    logic        kick;
    logic [21:0] micro;
    logic [31:0] angle;
    logic [2:0]  mode;
  } move_result_t;

  logic clk, rst_n;
  logic cfg_we;
  cfg_idx_e cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  move_word_t word;
  move_result_t got;

  // predictor copy of registers and per-motor state
  logic [23:0] p_min_speed;
  logic [31:0] p_kick_timeout;
  logic        p_kick_enable;
  logic [7:0]  p_microsteps;
  motor_mode_e p_mode [NumMotors];
  logic [21:0] p_last_pos [NumMotors];
  logic [31:0] p_timer [NumMotors];

  move_result_t expected_results[$];
  int  mismatches;
  longint cycles;
  bit  idle_free;

  stepper_velocity_command_sequencer u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .motor_index_i(word.motor), .angle_rate_i(word.rate), .period_i(word.period),
    .speed_limit_i(word.speed_limit), .steps_per_degree_i(word.spd),
    .driver_busy_i(word.busy), .driver_position_i(word.pos),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .command_o(got.cmd), .direction_o(got.dir), .run_speed_o(got.speed),
    .kick_o(got.kick), .moved_microsteps_o(got.micro), .moved_angle_o(got.angle),
    .motor_mode_out_o(got.mode)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] g, input logic [31:0] e);
    $display("mismatch %s: got %0h expected %0h at %0t", what, g, e, $time);
    mismatches++;
  endtask

  function automatic void reset_predictor();
    p_min_speed = 24'd2560;
    p_kick_timeout = 32'd327680;
    p_kick_enable = 1'b1;
    p_microsteps = 8'd16;
    for (int i = 0; i < NumMotors; i++) begin
      p_mode[i] = MODE_STOPPED;
      p_last_pos[i] = '0;
      p_timer[i] = '0;
    end
  endfunction

  function automatic void predict_move(input move_word_t w);
    move_result_t r;
    logic [31:0] mag;
    logic [63:0] prod, speed, cap, t, delta, dmag, dv, amag;
    logic fwd, neg;
    int m;
    if (w.motor >= NumMotors) return;
    m = w.motor;
    mag = w.rate[31] ? -w.rate : w.rate;
    prod = 64'(w.spd) * 64'(mag);
    fwd = !w.rate[31] && prod != 0;
    cap = 64'(w.speed_limit) << 8;
    if (prod == 0) speed = 0;
    else if (w.period == 0) speed = cap;
    else speed = prod / 64'(w.period);
    if (speed > cap) speed = cap;
    r.kick = 1'b0;
    if (p_kick_enable && speed != 0) begin
      if (speed < 64'(p_min_speed)) begin
        if (p_timer[m] >= p_kick_timeout) begin
          r.kick = 1'b1;
          p_timer[m] = '0;
        end else begin
          t = 64'(p_timer[m]) + 64'(w.period);
          p_timer[m] = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
        end
      end else begin
        p_timer[m] = '0;
      end
    end
    r.cmd = CMD_NONE;
    case (p_mode[m])
      MODE_STOPPED: begin
        r.cmd = CMD_RUN;
        p_mode[m] = fwd ? MODE_FWD : MODE_REV;
      end
      MODE_FWD: begin
        if (fwd) r.cmd = CMD_RUN;
        else begin
          r.cmd = CMD_SOFT_STOP;
          p_mode[m] = MODE_FWD_STOPPING;
        end
      end
      MODE_REV: begin
        if (!fwd) r.cmd = CMD_RUN;
        else begin
          r.cmd = CMD_SOFT_STOP;
          p_mode[m] = MODE_REV_STOPPING;
        end
      end
      default: if (!w.busy) p_mode[m] = MODE_STOPPED;
    endcase
    delta = 64'(22'(w.pos - p_last_pos[m]));
    neg = delta[21];
    dmag = neg ? (64'd1 << 22) - delta : delta;
    p_last_pos[m] = w.pos;
    r.micro = delta[21:0];
    dv = 64'(p_microsteps) * 64'(w.spd);
    if (dv == 0) r.angle = '0;
    else begin
      amag = (dmag << 24) / dv;
      if (neg) begin
        if (amag > 64'h8000_0000) amag = 64'h8000_0000;
        r.angle = -amag[31:0];
      end else begin
        if (amag > 64'h7FFF_FFFF) amag = 64'h7FFF_FFFF;
        r.angle = amag[31:0];
      end
    end
    r.dir = !fwd;
    r.speed = speed[23:0];
    r.mode = p_mode[m];
    expected_results.push_back(r);
  endfunction

  // result side: random stall, compare against the oldest expectation
  always @(posedge clk) begin
    move_result_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) report("unexpected word", 0, 0);
      else begin
        e = expected_results.pop_front();
        if (got.cmd !== e.cmd) report("command", got.cmd, e.cmd);
        if (got.dir !== e.dir) report("direction", got.dir, e.dir);
        if (got.speed !== e.speed) report("run_speed", got.speed, e.speed);
        if (got.kick !== e.kick) report("kick", got.kick, e.kick);
        if (got.micro !== e.micro) report("moved_microsteps", got.micro, e.micro);
        if (got.angle !== e.angle) report("moved_angle", got.angle, e.angle);
        if (got.mode !== e.mode) report("motor_mode_out", got.mode, e.mode);
      end
    end
    out_stall <= !idle_free && ($urandom_range(99) < 14);
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MIN_SPEED:    p_min_speed = val[23:0];
      CFG_KICK_TIMEOUT: p_kick_timeout = val;
      CFG_KICK_ENABLE:  p_kick_enable = val[0];
      default:          p_microsteps = val[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for all results, then let the clock run on idle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // send one word, holding it until accepted; random gaps before it
  task automatic send(input move_word_t w);
    bit gap;
    gap = !idle_free && ($urandom_range(99) < 14);
    if (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!idle_free && $urandom_range(99) < 14) @(posedge clk);
    end
    in_valid <= 1'b1;
    word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_move(w);
  endtask

  function automatic move_word_t random_word();
    move_word_t w;
    w.motor = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1));
    case ($urandom_range(3))
      0: w.rate = $urandom();
      1: w.rate = 32'($signed($urandom_range(4000)) - 2000) <<< $urandom_range(16);
      2: w.rate = 32'($urandom_range(255));
      default: w.rate = $urandom_range(1) ? 32'h8000_0000 : 32'(-$urandom_range(300));
    endcase
    case ($urandom_range(3))
      0: w.period = $urandom();
      1: w.period = 32'($urandom_range(3)) * 32'h1_0000 + $urandom_range(65535);
      2: w.period = 32'($urandom_range(2000));
      default: w.period = 32'h1_0000;
    endcase
    w.speed_limit = $urandom_range(1) ? 16'($urandom()) : 16'($urandom_range(40));
    w.spd = $urandom_range(1) ? 20'($urandom()) : 20'($urandom_range(1, 300));
    if (w.spd == 0) w.spd = 20'd1;
    w.busy = 1'($urandom_range(1));
    w.pos = $urandom_range(1) ? 22'($urandom()) : 22'($urandom_range(4000));
    return w;
  endfunction

  move_word_t table_words [DirectedRows];
  move_result_t table_results [DirectedRows];
  bit table_typed [DirectedRows];

  initial begin
    move_word_t w;
    mismatches = 0;
    cycles = 0;
    idle_free = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_SPEED;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    word = '0;
    reset_predictor();
    // directed table: motor, rate, period, speed_limit, spd, busy, pos
    table_words[0]  = {2'd0, 32'h0100_0000, 32'h1_0000, 16'd100, 20'd1, 1'b0, 22'd0};
    table_results[0] = {CMD_RUN, 1'b0, 24'd256, 1'b0, 22'd0, 32'd0, MODE_FWD};
    table_typed[0] = 1;
    table_words[1]  = {2'd2, 32'h0100_0000, 32'h1_0000, 16'd100, 20'd1, 1'b0, 22'd5};
    table_words[2]  = {2'd3, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 20'hFFFFF, 1'b1, 22'h3FFFFF};
    table_words[3]  = {2'd0, 32'h0000_0000, 32'h1_0000, 16'd100, 20'd1, 1'b1, 22'd16};
    table_results[3] = {CMD_SOFT_STOP, 1'b1, 24'd0, 1'b0, 22'd16, 32'h0100_0000,
                        MODE_FWD_STOPPING};
    table_typed[3] = 1;
    table_words[4]  = {2'd0, 32'h0100_0000, 32'h1_0000, 16'd100, 20'd1, 1'b1, 22'd16};
    table_words[5]  = {2'd0, 32'h0100_0000, 32'h1_0000, 16'd100, 20'd1, 1'b0, 22'd0};
    table_words[6]  = {2'd1, 32'h8000_0000, 32'd0, 16'hFFFF, 20'hFFFFF, 1'b0, 22'h200000};
    table_words[7]  = {2'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 1'b1,
                       22'h1FFFFF};
    table_words[8]  = {2'd1, 32'h7FFF_FFFF, 32'd1, 16'd0, 20'd1, 1'b0, 22'h3FFFFF};
    table_words[9]  = {2'd1, 32'h7FFF_FFFF, 32'd1, 16'd0, 20'd1, 1'b0, 22'h3FFFFF};
    table_words[10] = {2'd1, 32'h0000_0001, 32'd0, 16'd5, 20'd1, 1'b0, 22'd0};
    for (int i = 11; i < DirectedRows; i++) begin
      // low speed repeated to build up the kick timer
      table_words[i] = {2'd0, 32'h0001_0000, 32'h2_0000, 16'd10, 20'd2, 1'b1, 22'(i * 1000)};
      table_typed[i] = 0;
    end
    for (int i = 0; i < 11; i++) if (i != 0 && i != 3) table_typed[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirectedRows; i++) begin
      if (table_typed[i]) begin
        send(table_words[i]);
        void'(expected_results.pop_back());
        expected_results.push_back(table_results[i]);
      end else send(table_words[i]);
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MIN_SPEED, 32'hFF_FFFF);
          write_reg(CFG_KICK_TIMEOUT, 32'd0);
          write_reg(CFG_KICK_ENABLE, 32'd1);
          write_reg(CFG_MICROSTEPS, 32'd1);
        end
        1: begin
          write_reg(CFG_MIN_SPEED, 32'd0);
          write_reg(CFG_KICK_TIMEOUT, 32'hFFFF_FFFF);
          write_reg(CFG_MICROSTEPS, 32'd128);
        end
        2: begin
          write_reg(CFG_KICK_ENABLE, 32'd0);
          write_reg(CFG_MICROSTEPS, 32'd255);
        end
        3: begin
          write_reg(CFG_KICK_ENABLE, 32'd1);
          write_reg(CFG_MIN_SPEED, $urandom_range(24'hFF_FFFF));
          write_reg(CFG_KICK_TIMEOUT, $urandom_range(32'h8_0000));
          write_reg(CFG_MICROSTEPS, 32'd0);
        end
        4: begin
          write_reg(CFG_MIN_SPEED, 32'd2560);
          write_reg(CFG_KICK_TIMEOUT, 32'd327680);
          write_reg(CFG_MICROSTEPS, 32'd16);
          idle_free = 1'b1;
        end
        default: begin
          idle_free = 1'b0;
          write_reg(CFG_MICROSTEPS, 32'($urandom_range(1, 128)));
        end
      endcase
      for (int n = 0; n < RandomWords / 6; n++) begin
        w = random_word();
        send(w);
        if (n == 100) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_results.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
